>>> design/bra_pkg.sv
// ----------------------------------------------------------------------------
// bra_pkg
// Types and constants shared by the bitmap run allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bra_pkg;

	localparam int MAP_BYTES_DEF = 512;

	typedef enum logic [1:0] {
		KIND_SCAN  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_TEST  = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [12:0] run_length;
		logic [11:0] bit_index;
		logic        bit_value;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [11:0] run_start;
		logic        tested_bit;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_TEST,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

>>> design/bra_ram.sv
// ----------------------------------------------------------------------------
// bra_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> design/bitmap_run_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_run_allocator
// First-fit allocation bitmap held in a byte-wide RAM.
//
// Requests enter on req/req_valid and are taken when req_stall is low; one
// response per request leaves on rsp/rsp_valid, taken when rsp_stall is low.
// One request is worked on at a time; req_stall is high while it is busy.
// A scan reads the map one byte per cycle from byte 0 and evaluates all eight
// bits of that byte at once, until a run is found or the map ends. Write goes
// through read, modify-write and response; test through read, test and
// response; clear zeroes one byte per cycle, then responds. A scan with
// run_length 0 goes straight to the response.
// After reset the block zeroes the RAM with req_stall high. A finished
// response waits in an output register; while rsp_stall holds it, the next
// request is still taken and worked on, and its response waits in the block
// until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_run_allocator #(
	parameter int MAP_BYTES = bra_pkg::MAP_BYTES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire bra_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output bra_pkg::rsp_t      rsp
);

	import bra_pkg::*;

	localparam int AW   = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int CW   = AW + 1;
	localparam int BW   = $clog2(MAP_BYTES * 8 + 1);
	localparam int CMPW = (BW + 1 > 13) ? BW + 1 : 13;

	localparam logic [CW-1:0] DEPTH_C = CW'(MAP_BYTES);
	localparam logic [CW-1:0] LAST_C  = CW'(MAP_BYTES - 1);

	state_t          state_q, state_d;
	logic [CW-1:0]   addr_q, addr_d;
	logic            rvalid_s1, rvalid_d;
	logic [AW-1:0]   raddr_s1, raddr_d;
	logic            clr_rsp_q, clr_rsp_d;
	logic [BW-1:0]   zeros_q, zeros_d;
	logic [BW-1:0]   rstart_q, rstart_d;
	req_t            req_q, req_d;
	logic            in_range_q, in_range_d;
	rsp_t            res_q, res_d;
	logic            rsp_valid_q;
	rsp_t            rsp_q;
	logic            load_rsp;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [7:0]      ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [7:0]      ram_rdata;

	logic [3:0]      tz;
	logic [3:0]      lz;
	logic [3:0]      lc;
	logic            seen;
	logic            lz_done;
	logic            int_hit;
	logic [2:0]      hit_pos;
	logic [BW:0]     pre_sum;
	logic            pre_hit;
	logic [BW-1:0]   base;
	logic [BW-1:0]   pre_start;
	logic [BW-1:0]   int_start;
	logic [BW-1:0]   hit_start;
	logic            all_zero;
	logic [7:0]      bit_mask;
	logic [AW-1:0]   byte_addr_q;

	bra_ram #(
		.WIDTH(8),
		.DEPTH(MAP_BYTES),
		.AW   (AW)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// byte evaluation for the scan
	always_comb begin
		tz      = '0;
		lz      = '0;
		lc      = '0;
		seen    = 1'b0;
		lz_done = 1'b0;
		int_hit = 1'b0;
		hit_pos = '0;
		for (int b = 0; b < 8; b++) begin
			if (ram_rdata[b]) begin
				seen = 1'b1;
				lc   = '0;
			end else if (!seen) begin
				tz = tz + 4'd1;
			end else if (!int_hit) begin
				lc = lc + 4'd1;
				if (13'(lc) == req_q.run_length) begin
					int_hit = 1'b1;
					hit_pos = 3'(b);
				end
			end
		end
		for (int b = 7; b >= 0; b--) begin
			if (ram_rdata[b]) begin
				lz_done = 1'b1;
			end else if (!lz_done) begin
				lz = lz + 4'd1;
			end
		end
	end

	assign all_zero  = (ram_rdata == 8'h00);
	assign base      = BW'({raddr_s1, 3'b000});
	assign pre_sum   = (BW+1)'(zeros_q) + (BW+1)'(tz);
	assign pre_hit   = CMPW'(pre_sum) >= CMPW'(req_q.run_length);
	assign pre_start = (zeros_q == '0) ? base : rstart_q;
	assign int_start = base + BW'(hit_pos) + BW'(1) - BW'(req_q.run_length[3:0]);
	assign hit_start = pre_hit ? pre_start : int_start;

	assign byte_addr_q = AW'(req_q.bit_index[11:3]);
	assign bit_mask    = 8'(1) << req_q.bit_index[2:0];

	always_comb begin
		state_d    = state_q;
		addr_d     = addr_q;
		rvalid_d   = 1'b0;
		raddr_d    = raddr_s1;
		clr_rsp_d  = clr_rsp_q;
		zeros_d    = zeros_q;
		rstart_d   = rstart_q;
		req_d      = req_q;
		in_range_d = in_range_q;
		res_d      = res_q;
		load_rsp   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wdata  = '0;
		ram_raddr  = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = addr_q[AW-1:0];
				if (addr_q == LAST_C) begin
					addr_d = '0;
					if (clr_rsp_q) begin
						clr_rsp_d = 1'b0;
						res_d     = '0;
						state_d   = ST_RESP;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					addr_d = addr_q + CW'(1);
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					req_d      = req;
					in_range_d = 32'(req.bit_index) < 32'(MAP_BYTES * 8);
					res_d      = '0;
					ram_raddr  = AW'(req.bit_index[11:3]);
					case (req.kind)
						KIND_SCAN: begin
							if (req.run_length == '0) begin
								state_d = ST_RESP;
							end else begin
								ram_raddr = '0;
								rvalid_d  = 1'b1;
								raddr_d   = '0;
								addr_d    = CW'(1);
								zeros_d   = '0;
								rstart_d  = '0;
								state_d   = ST_SCAN;
							end
						end
						KIND_WRITE: state_d = ST_WRITE;
						KIND_TEST:  state_d = ST_TEST;
						KIND_CLEAR: begin
							addr_d    = '0;
							clr_rsp_d = 1'b1;
							state_d   = ST_CLEAR;
						end
						default: state_d = ST_RESP;
					endcase
				end
			end
			ST_SCAN: begin
				if (addr_q < DEPTH_C) begin
					ram_raddr = addr_q[AW-1:0];
					rvalid_d  = 1'b1;
					raddr_d   = addr_q[AW-1:0];
					addr_d    = addr_q + CW'(1);
				end
				if (rvalid_s1) begin
					if (pre_hit || int_hit) begin
						res_d.found     = 1'b1;
						res_d.run_start = 12'(hit_start);
						state_d         = ST_RESP;
					end else if (all_zero) begin
						zeros_d  = zeros_q + BW'(8);
						rstart_d = pre_start;
					end else begin
						zeros_d  = BW'(lz);
						rstart_d = base + BW'(8) - BW'(lz);
					end
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_WRITE: begin
				if (in_range_q) begin
					ram_we    = 1'b1;
					ram_waddr = byte_addr_q;
					ram_wdata = req_q.bit_value ? (ram_rdata | bit_mask)
					                            : (ram_rdata & ~bit_mask);
				end
				state_d = ST_RESP;
			end
			ST_TEST: begin
				res_d.tested_bit = in_range_q & ram_rdata[req_q.bit_index[2:0]];
				state_d          = ST_RESP;
			end
			ST_RESP: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			addr_q      <= '0;
			rvalid_s1   <= 1'b0;
			clr_rsp_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			addr_q    <= addr_d;
			rvalid_s1 <= rvalid_d;
			clr_rsp_q <= clr_rsp_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		raddr_s1   <= raddr_d;
		zeros_q    <= zeros_d;
		rstart_q   <= rstart_d;
		req_q      <= req_d;
		in_range_q <= in_range_d;
		res_q      <= res_d;
		if (load_rsp) begin
			rsp_q <= res_q;
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
